// ----- hw/rtl/ila_pkg.sv -----
// ila_pkg: shared types and constants of the interval lane assigner
// holds the result record, field widths and default parameter values
// no dependencies
package ila_pkg;

	localparam int MAX_LANES_DEF = 16;
	localparam int TIME_BITS_DEF = 48;

	localparam int DAY_W  = 16;
	localparam int TAG_W  = 16;
	localparam int CNUM_W = 16;
	localparam int LIDX_W = 4;
	localparam int LTOT_W = 5;

	typedef enum logic {
		KIND_ITEM  = 1'b0,
		KIND_CLOSE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [TAG_W-1:0]   tag;
		logic [CNUM_W-1:0]  cnum;
		logic [LIDX_W-1:0]  lane;
		logic [LTOT_W-1:0]  total;
		logic               laid;
		logic               ovf;
		logic               run_end;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

// ----- hw/rtl/ila_lane_cell.sv -----
// ila_lane_cell: one lane of the lane chain, holds the lane's end time
// passes the first-free-lane search on to the next cell
// depends on ila_pkg
module ila_lane_cell import ila_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int LANE_W    = 4,
	parameter int CNT_W     = 5,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  logic [TIME_BITS-1:0] start,
	input  logic [CNT_W-1:0]     used_cnt,
	input  logic                 found_in,
	input  logic [LANE_W-1:0]    lane_in,
	output logic                 found_out,
	output logic [LANE_W-1:0]    lane_out,
	input  logic                 wr_en,
	input  logic [LANE_W-1:0]    wr_lane,
	input  logic [TIME_BITS-1:0] wr_end
);

	logic [TIME_BITS-1:0] end_q;
	logic                 hit;

	assign hit       = (CNT_W'(IDX) < used_cnt) && (end_q <= start);
	assign found_out = found_in || hit;
	assign lane_out  = found_in ? lane_in : (hit ? LANE_W'(IDX) : lane_in);

	always_ff @(posedge clk) begin
		if (wr_en && (wr_lane == LANE_W'(IDX))) begin
			end_q <= wr_end;
		end
	end

endmodule

// ----- hw/rtl/interval_lane_assigner.sv -----
// interval_lane_assigner: greedy interval partitioning of timed items into lanes
// top level, cluster state, result buffer and the chain of ila_lane_cell
// depends on ila_pkg, ila_lane_cell
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_ready | day_number start_time end_time all_day
//          |                     | item_tag final_item
//  out     | out_valid/out_ready | result_kind tag_out cluster_number lane_index
//          |                     | lane_total laid_out lane_overflow run_end
//
// one item at a time: a transfer in, the CALC state for lane search and state update,
// then the EMIT state, which offers the results (one to three) in turn and leaves
// once out has taken the last; the search is one pass down the lane cell chain.
// arst_n clears control and cluster flags and counts; times and day need no clear.
// a stalled out holds the current result and keeps in_ready low.
module interval_lane_assigner import ila_pkg::*; #(
	parameter int MAX_LANES = MAX_LANES_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DAY_W-1:0]     day_number,
	input  logic [TIME_BITS-1:0] start_time,
	input  logic [TIME_BITS-1:0] end_time,
	input  logic                 all_day,
	input  logic [TAG_W-1:0]     item_tag,
	input  logic                 final_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 result_kind,
	output logic [TAG_W-1:0]     tag_out,
	output logic [CNUM_W-1:0]    cluster_number,
	output logic [LIDX_W-1:0]    lane_index,
	output logic [LTOT_W-1:0]    lane_total,
	output logic                 laid_out,
	output logic                 lane_overflow,
	output logic                 run_end
);

	localparam int LANE_W = $clog2(MAX_LANES);
	localparam int CNT_W  = $clog2(MAX_LANES + 1);

	state_t state_q;

	// captured item
	logic [DAY_W-1:0]     day_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] end_q;
	logic                 all_day_q;
	logic [TAG_W-1:0]     tag_q;
	logic                 final_q;

	// cluster state
	logic                 open_q;
	logic [DAY_W-1:0]     cur_day_q;
	logic [TIME_BITS-1:0] latest_q;
	logic [CNT_W-1:0]     lanes_q;
	logic [CNUM_W-1:0]    ctr_q;
	logic                 ovf_q;

	// result buffer
	res_t                 res_q [3];
	logic [1:0]           res_cnt_q;

	// lane chain
	logic                 found_c [MAX_LANES+1];
	logic [LANE_W-1:0]    lane_c  [MAX_LANES+1];

	logic                 close_prev;
	logic                 close_fin;
	logic                 opening;
	logic                 open1;
	logic                 open2;
	logic [CNUM_W-1:0]    cnt1;
	logic [CNT_W-1:0]     eff_lanes;
	logic [CNT_W-1:0]     lanes2;
	logic                 ovf1;
	logic                 ovf2;
	logic [LANE_W-1:0]    lane_sel;
	logic [TIME_BITS-1:0] latest_n;
	logic                 cell_wr;
	res_t                 r_close_a;
	res_t                 r_item;
	res_t                 r_close_b;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	assign found_c[0] = 1'b0;
	assign lane_c[0]  = '0;
	assign cell_wr    = (state_q == ST_CALC) && !all_day_q;

	for (genvar i = 0; i < MAX_LANES; i++) begin : g_cell
		ila_lane_cell #(
			.TIME_BITS(TIME_BITS),
			.LANE_W   (LANE_W),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk      (clk),
			.start    (start_q),
			.used_cnt (eff_lanes),
			.found_in (found_c[i]),
			.lane_in  (lane_c[i]),
			.found_out(found_c[i+1]),
			.lane_out (lane_c[i+1]),
			.wr_en    (cell_wr),
			.wr_lane  (lane_sel),
			.wr_end   (end_q)
		);
	end

	always_comb begin
		close_prev = !all_day_q && open_q
			&& ((day_q != cur_day_q) || (start_q >= latest_q));
		cnt1      = close_prev ? ctr_q + 1'b1 : ctr_q;
		open1     = close_prev ? 1'b0 : open_q;
		opening   = !all_day_q && !open1;
		eff_lanes = opening ? '0 : lanes_q;
		ovf1      = opening ? 1'b0 : ovf_q;
		if (opening || (end_q > latest_q)) begin
			latest_n = end_q;
		end else begin
			latest_n = latest_q;
		end

		lane_sel = lane_c[MAX_LANES];
		lanes2   = eff_lanes;
		ovf2     = ovf1;
		if (all_day_q) begin
			lanes2 = lanes_q;
			ovf2   = ovf_q;
		end else if (!found_c[MAX_LANES]) begin
			if (eff_lanes < CNT_W'(MAX_LANES)) begin
				lane_sel = eff_lanes[LANE_W-1:0];
				lanes2   = eff_lanes + 1'b1;
			end else begin
				lane_sel = LANE_W'(MAX_LANES - 1);
				ovf2     = 1'b1;
			end
		end
		open2     = all_day_q ? open_q : 1'b1;
		close_fin = final_q && open2;

		r_close_a.kind    = KIND_CLOSE;
		r_close_a.tag     = '0;
		r_close_a.cnum    = ctr_q;
		r_close_a.lane    = '0;
		r_close_a.total   = LTOT_W'(lanes_q);
		r_close_a.laid    = 1'b1;
		r_close_a.ovf     = ovf_q;
		r_close_a.run_end = 1'b0;

		r_item.kind    = KIND_ITEM;
		r_item.tag     = tag_q;
		r_item.cnum    = all_day_q ? '0 : cnt1;
		r_item.lane    = all_day_q ? '0 : LIDX_W'(lane_sel);
		r_item.total   = '0;
		r_item.laid    = !all_day_q;
		r_item.ovf     = all_day_q ? 1'b0 : ovf2;
		r_item.run_end = !close_fin;

		r_close_b.kind    = KIND_CLOSE;
		r_close_b.tag     = '0;
		r_close_b.cnum    = cnt1;
		r_close_b.lane    = '0;
		r_close_b.total   = LTOT_W'(lanes2);
		r_close_b.laid    = 1'b1;
		r_close_b.ovf     = ovf2;
		r_close_b.run_end = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			day_q     <= day_number;
			start_q   <= start_time;
			end_q     <= end_time;
			all_day_q <= all_day;
			tag_q     <= item_tag;
			final_q   <= final_item;
		end
		if (state_q == ST_CALC) begin
			if (close_prev) begin
				res_q[0] <= r_close_a;
				res_q[1] <= r_item;
				res_q[2] <= r_close_b;
			end else begin
				res_q[0] <= r_item;
				res_q[1] <= r_close_b;
				res_q[2] <= r_close_b;
			end
			if (opening) begin
				cur_day_q <= day_q;
			end
			if (!all_day_q) begin
				latest_q <= latest_n;
			end
		end else if (out_valid && out_ready) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_cnt_q <= '0;
			open_q    <= 1'b0;
			lanes_q   <= '0;
			ctr_q     <= '0;
			ovf_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					res_cnt_q <= 2'd1 + {1'b0, close_prev} + {1'b0, close_fin};
					open_q    <= open2 && !close_fin;
					lanes_q   <= lanes2;
					ovf_q     <= ovf2;
					ctr_q     <= close_fin ? cnt1 + 1'b1 : cnt1;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_ready) begin
						res_cnt_q <= res_cnt_q - 1'b1;
						if (res_cnt_q == 2'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_kind    = res_q[0].kind;
	assign tag_out        = res_q[0].tag;
	assign cluster_number = res_q[0].cnum;
	assign lane_index     = res_q[0].lane;
	assign lane_total     = res_q[0].total;
	assign laid_out       = res_q[0].laid;
	assign lane_overflow  = res_q[0].ovf;
	assign run_end        = res_q[0].run_end;

endmodule
